FILE: src/calm_pkg.sv
// Shared types, codes and helpers for the CIDR allow list match unit.
// No dependencies; imported by calm_ram users and the top level.
package calm_pkg;

   // Default table depth
   localparam int CALM_MAX_RULES = 16;

   // Request kinds (tuser low bits)
   localparam logic [1:0] REQ_QUERY = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // Load status codes
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_BAD_PREFIX = 2'd1;
   localparam logic [1:0] STAT_FULL       = 2'd2;

   // Prefix limits and IPv4-mapped form
   localparam logic [7:0]  V6_MAX_PREFIX = 8'd128;
   localparam logic [7:0]  V4_MAX_PREFIX = 8'd32;
   localparam logic [7:0]  V4_OFFSET     = 8'd96;
   localparam logic [31:0] MAPPED_MARK   = 32'h0000_FFFF;

   // One stored rule: network bits already masked to the prefix
   typedef struct packed {
      logic [63:0] upper;
      logic [63:0] lower;
      logic [7:0]  length;
   } rule_type;

   // Leading-ones mask for a 128-bit prefix; lengths of 128 and up give all ones
   function automatic logic [127:0] prefix_mask(input logic [7:0] len);
      logic [127:0] ones;
      ones = '1;
      return ~(ones >> len);
   endfunction

endpackage

FILE: src/calm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module calm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/cidr_allow_list_match_unit.sv
// CIDR allow list match unit: rule table in one RAM, one rule read per cycle.
// Flow: an accepted word passes ST_EXEC, then ST_RESP, which loads the output register; a
// scanning query runs ST_SCAN in between, reading rules one by one through the single RAM read port.
// Only one word is in flight: the next word is taken the cycle after the result is queued.
// Reset: synchronous, clears the rule count and handshake state; the rule RAM is not
// cleared (only entries below the count are ever read). Depends on calm_pkg, calm_ram.
module cidr_allow_list_match_unit #(
   parameter int MAX_RULES = calm_pkg::CALM_MAX_RULES
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // address_high[63:0], address_low[127:64], prefix_len[135:128],
   // is_local_peer[136], zero pad [143:137]
   input  logic [143:0] req_tdata,
   // req_type[1:0], ipv4_form[2]
   input  logic [2:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // allowed[0], status[2:1], rules_held[7:3]
   output logic [7:0]   rsp_tdata
);
   import calm_pkg::*;

   localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W = $clog2(MAX_RULES + 1);
   localparam int RULE_W = $bits(rule_type);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [1:0]   kind_ff;
   logic         v4_ff;
   logic [63:0]  addr_hi_ff;
   logic [63:0]  addr_lo_ff;
   logic [7:0]   plen_ff;
   logic         local_ff;

   // table and scan control
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic             pend_ff, pend_in;

   // result staging and output register
   logic       allowed_ff, allowed_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   // RAM hookup
   logic              wr_en;
   rule_type          wr_rule;
   logic              rd_en;
   logic [RULE_W-1:0] rd_word;
   rule_type          rd_rule;
   logic              hit;

   // load formatting
   logic [7:0]   limit;
   logic [7:0]   eff_len;
   logic [127:0] eff_addr;
   logic [127:0] load_mask;
   logic         scan_issue;

   calm_ram #(
      .WIDTH (RULE_W),
      .DEPTH (MAX_RULES)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_rule),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_rule = rule_type'(rd_word);

   // compare the query address against the rule read last cycle
   assign hit = (({addr_hi_ff, addr_lo_ff} & prefix_mask(rd_rule.length)) ==
                 {rd_rule.upper, rd_rule.lower});

   // rule formatting for a load, IPv4 mapped to ::ffff:a.b.c.d
   always_comb begin
      limit     = v4_ff ? V4_MAX_PREFIX : V6_MAX_PREFIX;
      eff_len   = v4_ff ? (plen_ff + V4_OFFSET) : plen_ff;
      eff_addr  = v4_ff ? {64'd0, MAPPED_MARK, addr_lo_ff[31:0]} : {addr_hi_ff, addr_lo_ff};
      load_mask = prefix_mask(eff_len);
      wr_rule.upper  = eff_addr[127:64] & load_mask[127:64];
      wr_rule.lower  = eff_addr[63:0] & load_mask[63:0];
      wr_rule.length = eff_len;
   end

   assign scan_issue = (rd_cnt_ff < count_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_cnt_in    = rd_cnt_ff;
      pend_in      = pend_ff;
      allowed_in   = allowed_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      // output register drains independently
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            allowed_in = 1'b0;
            status_in  = STAT_OK;
            state_in   = ST_RESP;
            case (kind_ff)
               REQ_QUERY: begin
                  if (count_ff == '0 || local_ff) begin
                     allowed_in = 1'b1;
                  end else begin
                     rd_cnt_in = '0;
                     pend_in   = 1'b0;
                     state_in  = ST_SCAN;
                  end
               end
               REQ_LOAD: begin
                  if (plen_ff > limit) begin
                     status_in = STAT_BAD_PREFIX;
                  end else if (count_ff >= CNT_W'(MAX_RULES)) begin
                     status_in = STAT_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               REQ_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            // one read issued and one rule checked per cycle
            if (pend_ff && hit) begin
               allowed_in = 1'b1;
               pend_in    = 1'b0;
               state_in   = ST_RESP;
            end else if (!scan_issue && !pend_ff) begin
               state_in = ST_RESP;
            end else begin
               rd_en   = scan_issue;
               pend_in = scan_issue;
               if (scan_issue) begin
                  rd_cnt_in = rd_cnt_ff + 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'(count_ff), status_ff, allowed_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_cnt_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_cnt_ff    <= rd_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff    <= req_tuser[1:0];
         v4_ff      <= req_tuser[2];
         addr_hi_ff <= req_tdata[63:0];
         addr_lo_ff <= req_tdata[127:64];
         plen_ff    <= req_tdata[135:128];
         local_ff   <= req_tdata[136];
      end
      allowed_ff  <= allowed_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: tb/tb_cidr_allow_list_match_unit.sv
// Self-checking bench for cidr_allow_list_match_unit: directed prefix and table cases, then
// random rule loads, clears and queries, first with random idling on both sides, then with none.
// Depends on calm_pkg and the unit's RTL; keeps its own copy of the rule table.
module tb_cidr_allow_list_match_unit;
   import calm_pkg::*;

   localparam int          TABLE_DEPTH = CALM_MAX_RULES;
   localparam logic [1:0]  REQ_UNUSED  = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 400000;

   // One request word, unpacked
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0]  plen;
      logic        v4_form;
      logic        local_peer;
   } acl_item_type;

   // One response word, unpacked
   typedef struct packed {
      logic       allowed;
      logic [1:0] status;
      logic [4:0] held;
   } acl_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;   // address_high, address_low, prefix_len, is_local_peer, pad
   logic [2:0]   req_tuser;   // req_type, ipv4_form
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;   // allowed, status, rules_held

   // Shadow rule table
   logic [127:0] rule_net [TABLE_DEPTH];
   int unsigned  rule_len [TABLE_DEPTH];
   int unsigned  rule_count;

   acl_result_type pending_results[$];
   int unsigned    mismatch_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    stall_left;
   bit             gaps_on;
   bit             stalls_on;

   cidr_allow_list_match_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Leading-ones mask of len bits over the 128-bit address
   function automatic logic [127:0] lead_mask(input int unsigned len);
      logic [127:0] m;
      m = '0;
      for (int b = 0; b < 128; b++) begin
         if (b < len) m[127 - b] = 1'b1;
      end
      return m;
   endfunction

   // Apply one word to the shadow table and return the response it should give
   function automatic acl_result_type acl_predict(input acl_item_type it);
      acl_result_type res;
      logic [127:0]   addr;
      int unsigned    len;
      int unsigned    limit;
      res = '0;
      addr = {it.addr_hi, it.addr_lo};
      case (it.kind)
         REQ_QUERY: begin
            if (rule_count == 0 || it.local_peer) begin
               res.allowed = 1'b1;
            end else begin
               for (int i = 0; i < rule_count; i++) begin
                  if ((addr & lead_mask(rule_len[i])) == rule_net[i]) res.allowed = 1'b1;
               end
            end
         end
         REQ_LOAD: begin
            limit = it.v4_form ? V4_MAX_PREFIX : V6_MAX_PREFIX;
            len = it.plen;
            if (len > limit) begin
               res.status = STAT_BAD_PREFIX;
            end else if (rule_count >= TABLE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               // IPv4 rules live as ::ffff:a.b.c.d
               if (it.v4_form) begin
                  addr = {64'h0, MAPPED_MARK, it.addr_lo[31:0]};
                  len = len + V4_OFFSET;
               end
               rule_net[rule_count] = addr & lead_mask(len);
               rule_len[rule_count] = len;
               rule_count++;
            end
         end
         REQ_CLEAR: rule_count = 0;
         default: ;
      endcase
      res.held = 5'(rule_count);
      return res;
   endfunction

   function automatic acl_item_type item_of(input logic [1:0] kind, input logic [127:0] addr,
                                            input logic [7:0] plen, input logic v4_form,
                                            input logic local_peer);
      acl_item_type it;
      it.kind = kind;
      {it.addr_hi, it.addr_lo} = addr;
      it.plen = plen;
      it.v4_form = v4_form;
      it.local_peer = local_peer;
      return it;
   endfunction

   function automatic logic [127:0] rand_addr();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // Rule load, mostly legal lengths with the bounds favored
   function automatic acl_item_type make_load();
      acl_item_type it;
      int unsigned  r;
      it = item_of(REQ_LOAD, rand_addr(), 8'd0, $urandom_range(0, 9) < 3,
                   1'($urandom_range(0, 1)));
      r = $urandom_range(0, 19);
      if (it.v4_form) begin
         if (r == 0)      it.plen = 8'($urandom_range(33, 255));
         else if (r == 1) it.plen = V4_MAX_PREFIX;
         else if (r == 2) it.plen = 8'd0;
         else             it.plen = 8'($urandom_range(0, 32));
      end else begin
         if (r == 0)      it.plen = 8'($urandom_range(129, 255));
         else if (r == 1) it.plen = V6_MAX_PREFIX;
         else if (r == 2) it.plen = 8'd0;
         else             it.plen = 8'($urandom_range(0, 128));
      end
      return it;
   endfunction

   // Query aimed at a held rule most of the time, sometimes one bit off inside the prefix
   function automatic acl_item_type make_query();
      acl_item_type it;
      logic [127:0] addr;
      int unsigned  idx;
      int unsigned  r;
      r = $urandom_range(0, 9);
      addr = rand_addr();
      if (rule_count != 0 && r < 7) begin
         idx = $urandom_range(0, rule_count - 1);
         addr = rule_net[idx] | (addr & ~lead_mask(rule_len[idx]));
         if (r < 2 && rule_len[idx] != 0)
            addr[127 - $urandom_range(0, rule_len[idx] - 1)] ^= 1'b1;
      end else if (r == 9) begin
         addr = {64'h0, MAPPED_MARK, addr[31:0]};
      end
      it = item_of(REQ_QUERY, addr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 4) == 0);
      return it;
   endfunction

   function automatic acl_item_type random_item();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return make_query();
      if (r < 94) return make_load();
      return item_of(r < 97 ? REQ_CLEAR : REQ_UNUSED, rand_addr(),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
   endfunction

   // Drive one request word and log its expected response once accepted
   task automatic send_word(input acl_item_type it);
      int unsigned gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {7'b0, it.local_peer, it.plen, it.addr_lo, it.addr_hi};
      req_tuser  <= {it.v4_form, it.kind};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results = {pending_results, acl_predict(it)};
   endtask

   // Hold off the request side until every response is back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_empty_table();
      send_word(item_of(REQ_QUERY, rand_addr(), 8'd0, 1'b0, 1'b0));
      send_word(item_of(REQ_QUERY, rand_addr(), 8'd255, 1'b1, 1'b1));
      send_word(item_of(REQ_UNUSED, rand_addr(), 8'd255, 1'b1, 1'b1));
      send_word(item_of(REQ_CLEAR, rand_addr(), 8'd0, 1'b0, 1'b0));
   endtask

   task automatic test_prefix_bounds();
      logic [127:0] host;
      logic [127:0] junk;
      logic [31:0]  v4_host;
      host = rand_addr();
      junk = rand_addr();
      v4_host = $urandom;
      // bounds of both forms; junk above the IPv4 field must not matter
      send_word(item_of(REQ_LOAD, host, V6_MAX_PREFIX, 1'b0, 1'b0));
      send_word(item_of(REQ_LOAD, host, 8'd129, 1'b0, 1'b0));
      send_word(item_of(REQ_LOAD, host, 8'd255, 1'b0, 1'b1));
      send_word(item_of(REQ_LOAD, {junk[127:32], v4_host}, V4_MAX_PREFIX, 1'b1, 1'b0));
      send_word(item_of(REQ_LOAD, junk, 8'd33, 1'b1, 1'b0));
      send_word(item_of(REQ_QUERY, host, 8'd0, 1'b0, 1'b0));
      send_word(item_of(REQ_QUERY, host ^ 128'd1, 8'd0, 1'b0, 1'b0));
      send_word(item_of(REQ_QUERY, {64'h0, MAPPED_MARK, v4_host}, 8'd0, 1'b0, 1'b0));
      send_word(item_of(REQ_QUERY, {64'h8000_0000_0000_0000, MAPPED_MARK, v4_host}, 8'd0,
                        1'b0, 1'b0));
      send_word(item_of(REQ_QUERY, junk, 8'd0, 1'b0, 1'b1));
      send_word(item_of(REQ_UNUSED, junk, 8'd7, 1'b0, 1'b0));
      send_word(item_of(REQ_CLEAR, junk, 8'd0, 1'b0, 1'b0));
      // zero-length rules in both forms
      send_word(item_of(REQ_LOAD, junk, 8'd0, 1'b1, 1'b0));
      send_word(item_of(REQ_QUERY, {64'h0, MAPPED_MARK, junk[31:0]}, 8'd0, 1'b0, 1'b0));
      send_word(item_of(REQ_QUERY, {64'hFFFF_FFFF_FFFF_FFFF, junk[63:0]}, 8'd0, 1'b0, 1'b0));
      send_word(item_of(REQ_LOAD, host, 8'd0, 1'b0, 1'b0));
      send_word(item_of(REQ_QUERY, rand_addr(), 8'd0, 1'b0, 1'b0));
      send_word(item_of(REQ_CLEAR, host, 8'd0, 1'b0, 1'b0));
   endtask

   // Fill the table, then hit it with a load while full and a bad prefix while full
   task automatic test_full_table();
      acl_item_type it;
      while (rule_count < TABLE_DEPTH) send_word(make_load());
      it = make_load();
      it.v4_form = 1'b0;
      it.plen = 8'($urandom_range(0, 128));
      send_word(it);
      it.plen = 8'd200;
      send_word(it);
      repeat (4) send_word(make_query());
      wait_for_results();
      send_word(item_of(REQ_CLEAR, rand_addr(), 8'd0, 1'b0, 1'b0));
   endtask

   task automatic test_random_traffic(input int unsigned count);
      for (int n = 0; n < count; n++) begin
         // idling switched per chunk so some stretches run flat out
         if (n % 50 == 0) begin
            gaps_on = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
         end
         send_word(random_item());
      end
   endtask

   task automatic test_quiet_traffic(input int unsigned count);
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      for (int n = 0; n < count; n++) send_word(random_item());
   endtask

   // Response side: random back-pressure and in-order compare
   always @(posedge clock) begin
      acl_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected rsp word %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[0] !== want.allowed) begin
                  $error("allowed: expected %0d, got %0d", want.allowed, rsp_tdata[0]);
                  mismatch_count++;
               end
               if (rsp_tdata[2:1] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[2:1]);
                  mismatch_count++;
               end
               if (rsp_tdata[7:3] !== want.held) begin
                  $error("rules_held: expected %0d, got %0d", want.held, rsp_tdata[7:3]);
                  mismatch_count++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 16);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      rule_count = 0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_prefix_bounds();
      test_full_table();
      test_random_traffic(500);
      test_quiet_traffic(80);

      wait_for_results();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
